FILE: design/triangle_flip_max_step_core_assert.svh
// Assertion macros used by the checker file tfm_checker.sv.
`ifndef TRIANGLE_FLIP_MAX_STEP_CORE_ASSERT_SVH
`define TRIANGLE_FLIP_MAX_STEP_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define TFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/tfm_pkg.sv
//------------------------------------------------------------------------------
// tfm_pkg
// Types and constants shared by the flip-step bound block.
//------------------------------------------------------------------------------
`default_nettype none
package tfm_pkg;
	localparam int unsigned MaxFaces = 1048576;
	localparam int unsigned CoefBits = 61;

	typedef struct packed {
		logic signed [31:0] u1_x;
		logic signed [31:0] u1_y;
		logic signed [31:0] u2_x;
		logic signed [31:0] u2_y;
		logic signed [31:0] u3_x;
		logic signed [31:0] u3_y;
		logic signed [31:0] d1_x;
		logic signed [31:0] d1_y;
		logic signed [31:0] d2_x;
		logic signed [31:0] d2_y;
		logic signed [31:0] d3_x;
		logic signed [31:0] d3_y;
	} tri_in_t;

	typedef struct packed {
		logic [31:0] step_bound;
		logic        step_finite;
	} step_out_t;

	// Reduced coefficients handed from the front to the back.
	typedef struct packed {
		logic        sa;
		logic        sb;
		logic        sc;
		logic [60:0] ma;
		logic [60:0] mb;
		logic [60:0] mc;
	} coef_t;
endpackage
`default_nettype wire

FILE: design/tfm_front.sv
//------------------------------------------------------------------------------
// tfm_front
// Accepts triangles, forms the area quadratic coefficients with one shared
// 33x33 multiplier over eight products, and reduces them to 61 bits.
//------------------------------------------------------------------------------
`default_nettype none
module tfm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tfm_pkg::tri_in_t in_data,
	output logic                q_valid,
	input  wire logic           q_ready,
	output tfm_pkg::coef_t      q_data
);
	typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED, S_OUT} state_t;
	state_t state_q;
	logic signed [32:0] ax_q, ay_q, bx_q, by_q, dax_q, day_q, dbx_q, dby_q;
	logic signed [67:0] wa_q, wb_q, wc_q;
	logic [2:0] idx_q;
	tfm_pkg::coef_t out_q;

	logic signed [32:0] opx, opy;
	logic signed [65:0] prod;
	logic neg;
	logic [1:0] tgt;
	logic [66:0] maga, magb, magc, mor;
	logic [6:0] bl;
	logic [6:0] sh;

	// Select the product for the current step.
	always_comb begin
		opx = ax_q; opy = by_q; neg = 1'b0; tgt = 2'd2;
		case (idx_q)
			3'd0: begin opx = ax_q;  opy = by_q;  neg = 1'b0; tgt = 2'd2; end
			3'd1: begin opx = ay_q;  opy = bx_q;  neg = 1'b1; tgt = 2'd2; end
			3'd2: begin opx = dax_q; opy = dby_q; neg = 1'b0; tgt = 2'd0; end
			3'd3: begin opx = day_q; opy = dbx_q; neg = 1'b1; tgt = 2'd0; end
			3'd4: begin opx = ax_q;  opy = dby_q; neg = 1'b0; tgt = 2'd1; end
			3'd5: begin opx = ay_q;  opy = dbx_q; neg = 1'b1; tgt = 2'd1; end
			3'd6: begin opx = dax_q; opy = by_q;  neg = 1'b0; tgt = 2'd1; end
			3'd7: begin opx = day_q; opy = bx_q;  neg = 1'b1; tgt = 2'd1; end
			default: begin opx = ax_q; opy = by_q; neg = 1'b0; tgt = 2'd2; end
		endcase
		prod = opx * opy;
	end

	// Magnitudes, common bit length and the shift that brings them below 2^61.
	always_comb begin
		maga = wa_q[67] ? 67'(-wa_q) : wa_q[66:0];
		magb = wb_q[67] ? 67'(-wb_q) : wb_q[66:0];
		magc = wc_q[67] ? 67'(-wc_q) : wc_q[66:0];
		mor = maga | magb | magc;
		bl = '0;
		for (int i = 0; i < 67; i++) begin
			if (mor[i]) bl = 7'(i + 1);
		end
		sh = (bl > 7'(tfm_pkg::CoefBits)) ? bl - 7'(tfm_pkg::CoefBits) : '0;
	end

	assign in_ready = (state_q == S_IDLE);
	assign q_valid = (state_q == S_OUT);
	assign q_data = out_q;

	// Sequencer for one triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ax_q <= 33'(in_data.u2_x) - 33'(in_data.u1_x);
						ay_q <= 33'(in_data.u2_y) - 33'(in_data.u1_y);
						bx_q <= 33'(in_data.u3_x) - 33'(in_data.u1_x);
						by_q <= 33'(in_data.u3_y) - 33'(in_data.u1_y);
						dax_q <= 33'(in_data.d2_x) - 33'(in_data.d1_x);
						day_q <= 33'(in_data.d2_y) - 33'(in_data.d1_y);
						dbx_q <= 33'(in_data.d3_x) - 33'(in_data.d1_x);
						dby_q <= 33'(in_data.d3_y) - 33'(in_data.d1_y);
						wa_q <= '0; wb_q <= '0; wc_q <= '0;
						idx_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					case (tgt)
						2'd0: wa_q <= neg ? wa_q - 68'(prod) : wa_q + 68'(prod);
						2'd1: wb_q <= neg ? wb_q - 68'(prod) : wb_q + 68'(prod);
						default: wc_q <= neg ? wc_q - 68'(prod) : wc_q + 68'(prod);
					endcase
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) state_q <= S_RED;
				end
				S_RED: begin
					out_q.sa <= wa_q[67];
					out_q.sb <= wb_q[67];
					out_q.sc <= wc_q[67];
					out_q.ma <= 61'(maga >> sh);
					out_q.mb <= 61'(magb >> sh);
					out_q.mc <= 61'(magc >> sh);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (q_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/tfm_fifo.sv
//------------------------------------------------------------------------------
// tfm_fifo
// Two-entry queue between the front and back parts.
//------------------------------------------------------------------------------
`default_nettype none
module tfm_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      w_valid,
	output logic           w_ready,
	input  wire tfm_pkg::coef_t w_data,
	output logic           r_valid,
	input  wire logic      r_ready,
	output tfm_pkg::coef_t r_data
);
	tfm_pkg::coef_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign w_ready = (cnt_q != 2'd2);
	assign r_valid = (cnt_q != 2'd0);
	assign r_data = mem_q[rp_q];
	assign wr = w_valid && w_ready;
	assign rd = r_valid && r_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

FILE: design/tfm_back.sv
//------------------------------------------------------------------------------
// tfm_back
// Solves the reduced quadratic with a shared 32x32 multiplier, a digit-serial
// square root and a bit-serial divider, and keeps the running minimum over one
// group of triangles.
//------------------------------------------------------------------------------
`default_nettype none
module tfm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [20:0]    face_count,
	input  wire logic           q_valid,
	output logic                q_ready,
	input  wire tfm_pkg::coef_t q_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tfm_pkg::step_out_t  out_data
);
	typedef enum logic [3:0] {
		B_IDLE, B_MUL, B_DISC, B_SQRT, B_ROOT, B_DIVI, B_DIVF, B_ACC, B_EMIT
	} state_t;
	state_t state_q;
	tfm_pkg::coef_t c_q;
	logic [127:0] bb_q, ac_q, d_q;
	logic [2:0] mcnt_q;
	logic [63:0] sqr_q;
	logic [64:0] srem_q;
	logic [5:0] bit_q;
	logic [63:0] den_q, rem_q;
	logic [79:0] quo_q;
	logic [6:0] dcnt_q;
	logic have_q;
	logic [31:0] t_q;
	logic [31:0] min_q;
	logic found_q;
	logic [20:0] seen_q;
	tfm_pkg::step_out_t out_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [6:0] mul_sh;
	logic [127:0] mul_acc;
	logic [127:0] ac4;
	logic [66:0] srem_sh, s_trial;
	logic s_take;
	logic signed [63:0] bv, np, nm;
	logic [64:0] rem_sh;
	logic [20:0] fc;
	logic [20:0] seen_n;

	// Effective group size.
	always_comb begin
		fc = face_count;
		if (fc == '0) fc = 21'd1;
		if (fc > 21'(tfm_pkg::MaxFaces)) fc = 21'(tfm_pkg::MaxFaces);
		seen_n = seen_q + 21'd1;
	end

	// Partial products of b*b (steps 0-3) and a*c (steps 4-7), split 32 low and 29 high.
	always_comb begin
		mul_a = c_q.mb[31:0]; mul_b = c_q.mb[31:0]; mul_sh = 7'd0;
		case (mcnt_q)
			3'd0: begin mul_a = c_q.mb[31:0]; mul_b = c_q.mb[31:0]; mul_sh = 7'd0; end
			3'd1: begin mul_a = c_q.mb[31:0]; mul_b = {3'b0, c_q.mb[60:32]}; mul_sh = 7'd32; end
			3'd2: begin mul_a = {3'b0, c_q.mb[60:32]}; mul_b = c_q.mb[31:0]; mul_sh = 7'd32; end
			3'd3: begin
				mul_a = {3'b0, c_q.mb[60:32]}; mul_b = {3'b0, c_q.mb[60:32]}; mul_sh = 7'd64;
			end
			3'd4: begin mul_a = c_q.ma[31:0]; mul_b = c_q.mc[31:0]; mul_sh = 7'd0; end
			3'd5: begin mul_a = c_q.ma[31:0]; mul_b = {3'b0, c_q.mc[60:32]}; mul_sh = 7'd32; end
			3'd6: begin mul_a = {3'b0, c_q.ma[60:32]}; mul_b = c_q.mc[31:0]; mul_sh = 7'd32; end
			3'd7: begin
				mul_a = {3'b0, c_q.ma[60:32]}; mul_b = {3'b0, c_q.mc[60:32]}; mul_sh = 7'd64;
			end
			default: begin mul_a = c_q.mb[31:0]; mul_b = c_q.mb[31:0]; mul_sh = 7'd0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;
	assign mul_acc = 128'(mul_p) << mul_sh;
	assign ac4 = {ac_q[125:0], 2'b00};

	// Square-root step: bring down two radicand bits, try the next root bit.
	always_comb begin
		srem_sh = {srem_q, d_q[127:126]};
		s_trial = {1'b0, sqr_q, 2'b01};
		s_take = (srem_sh >= s_trial);
		bv = c_q.sb ? -$signed({3'b0, c_q.mb}) : $signed({3'b0, c_q.mb});
		np = -bv + $signed(sqr_q);
		nm = -bv - $signed(sqr_q);
		rem_sh = {rem_q, quo_q[79]};
	end

	assign q_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_EMIT);
	assign out_data = out_q;

	// Back sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			min_q <= '1;
			found_q <= 1'b0;
			seen_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						c_q <= q_data;
						bb_q <= '0;
						ac_q <= '0;
						mcnt_q <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (!mcnt_q[2]) bb_q <= bb_q + mul_acc;
					else ac_q <= ac_q + mul_acc;
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd7) state_q <= B_DISC;
				end
				B_DISC: begin
					have_q <= 1'b0;
					sqr_q <= '0;
					srem_q <= '0;
					bit_q <= 6'd63;
					if (c_q.ma == '0) begin
						if (c_q.mb == '0 || c_q.mc == '0 || c_q.sb == c_q.sc) begin
							state_q <= B_ACC;
						end else begin
							den_q <= 64'(c_q.mb);
							state_q <= B_DIVI;
							quo_q <= {64'(c_q.mc), 16'b0};
							rem_q <= '0;
							dcnt_q <= 7'd80;
						end
					end else if (c_q.mc != '0 && c_q.sa != c_q.sc) begin
						d_q <= bb_q + ac4;
						state_q <= B_SQRT;
					end else if (ac4 > bb_q) begin
						state_q <= B_ACC;
					end else begin
						d_q <= bb_q - ac4;
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					d_q <= {d_q[125:0], 2'b00};
					sqr_q <= {sqr_q[62:0], s_take};
					srem_q <= s_take ? 65'(srem_sh - s_trial) : srem_sh[64:0];
					if (bit_q == '0) state_q <= B_ROOT;
					else bit_q <= bit_q - 6'd1;
				end
				B_ROOT: begin
					den_q <= {2'b0, c_q.ma, 1'b0};
					rem_q <= '0;
					dcnt_q <= 7'd80;
					state_q <= B_DIVI;
					if (!c_q.sa) begin
						if (nm > 0) quo_q <= {nm, 16'b0};
						else if (np > 0) quo_q <= {np, 16'b0};
						else state_q <= B_ACC;
					end else begin
						if (np < 0) quo_q <= {-np, 16'b0};
						else if (nm < 0) quo_q <= {-nm, 16'b0};
						else state_q <= B_ACC;
					end
				end
				B_DIVI: begin
					// Restoring division of num<<16 by den, one bit a cycle.
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= 64'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[78:0], 1'b1};
					end else begin
						rem_q <= rem_sh[63:0];
						quo_q <= {quo_q[78:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 7'd1;
					if (dcnt_q == 7'd1) state_q <= B_DIVF;
				end
				B_DIVF: begin
					have_q <= 1'b1;
					t_q <= (quo_q[79:32] != '0) ? '1 : quo_q[31:0];
					state_q <= B_ACC;
				end
				B_ACC: begin
					if (have_q) begin
						if (t_q < min_q) min_q <= t_q;
						found_q <= 1'b1;
					end
					if (seen_n >= fc) begin
						out_q.step_bound <= (have_q || found_q) ?
							((have_q && t_q < min_q) ? t_q : min_q) : '1;
						out_q.step_finite <= have_q || found_q;
						min_q <= '1;
						found_q <= 1'b0;
						seen_q <= '0;
						state_q <= B_EMIT;
					end else begin
						seen_q <= seen_n;
						state_q <= B_IDLE;
					end
				end
				B_EMIT: begin
					if (out_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/triangle_flip_max_step_core.sv
//------------------------------------------------------------------------------
// triangle_flip_max_step_core
// Smallest positive flip step over groups of triangles.
//------------------------------------------------------------------------------
// Each triangle passes through the front (eight products through one
// shared 33x33 multiplier, a reduction state and a hand-off state) and then
// the back: eight 32x32 partial products, then a 64-step square root and
// an 80-step restoring divider for a full quadratic. A negative
// discriminant leaves the back after the discriminant check, a degenerate
// quadratic skips the square root, and a quadratic with no positive root
// skips the divider. The last triangle of a group also waits in the emit
// state through any output stall. A two-entry queue lets the front take the next
// triangle while the back works. One result item leaves after every
// face_count triangles (zero counts as one, values above 2^20 as 2^20).
`default_nettype none
module triangle_flip_max_step_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [20:0]         cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tfm_pkg::tri_in_t    in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tfm_pkg::step_out_t       out_data
);
	logic [20:0] face_count_q;
	logic f_valid, f_ready, b_valid, b_ready;
	tfm_pkg::coef_t f_data, b_data;

	// Group size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) face_count_q <= 21'd1;
		else if (cfg_we) face_count_q <= cfg_wdata;
	end

	tfm_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid(f_valid), .q_ready(f_ready), .q_data(f_data));
	tfm_fifo u_fifo (.clk, .arst_n, .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
		.r_valid(b_valid), .r_ready(b_ready), .r_data(b_data));
	tfm_back u_back (.clk, .arst_n, .face_count(face_count_q),
		.q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
		.out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

FILE: design/tfm_checker.sv
//------------------------------------------------------------------------------
// tfm_checker
// Port-level checks on the flip-step bound block.
//------------------------------------------------------------------------------
`default_nettype none
`include "triangle_flip_max_step_core_assert.svh"
module tfm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire tfm_pkg::step_out_t out_data
);
	`TFM_ASSERT_IMPL(a_inf_sat, clk, arst_n, out_valid && !out_data.step_finite, out_data.step_bound == 32'hFFFFFFFF)
	`TFM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`TFM_ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && out_ready, !out_valid)
endmodule
bind triangle_flip_max_step_core tfm_checker u_chk (.clk, .arst_n, .out_valid, .out_ready,
	.out_data);
`default_nettype wire
